### src/keyed_cell_interval_encoder_unit_defines.svh
// ----------------------------------------------------------------------------
// Keyed cell interval encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef KEYED_CELL_INTERVAL_ENCODER_UNIT_DEFINES_SVH
`define KEYED_CELL_INTERVAL_ENCODER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KCIE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KCIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/kcie_pkg.sv
// ----------------------------------------------------------------------------
// kcie_pkg
// Types and constants shared by the keyed cell interval encoder.
// ----------------------------------------------------------------------------
package kcie_pkg;

  localparam int MAX_MSG = 16;
  localparam int VW      = 32;
  localparam int PW      = 2 * VW;
  localparam int IW      = $clog2(MAX_MSG);
  localparam int MCW     = 5;
  localparam int CIW     = 2;
  localparam int Q_DEPTH = 2;
  localparam int DIV_CW  = $clog2(VW);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ENC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  localparam logic [CIW-1:0] CFG_MSG_COUNT  = 2'd0;
  localparam logic [CIW-1:0] CFG_KEY_COUNT  = 2'd1;
  localparam logic [CIW-1:0] CFG_MODULUS    = 2'd2;
  localparam logic [CIW-1:0] CFG_CELL_WIDTH = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_ENC,
    OP_DEC,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t           op;
    logic [IW-1:0] message;
    logic [IW-1:0] table_index;
    logic [VW-1:0] table_word;
    logic [VW-1:0] ciphertext;
    logic [VW-1:0] key;
    logic [VW-1:0] random_word;
  } cmd_t;

  typedef struct packed {
    logic [MCW-1:0] msg_count;
    logic [VW-1:0]  key_count;
    logic [VW-1:0]  modulus;
    logic [VW-1:0]  cell_width;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENC_A,
    S_ENC_B,
    S_ENC_C,
    S_ENC_DIV,
    S_ENC_SUM,
    S_ENC_WRAP,
    S_DEC_A,
    S_DEC_B,
    S_DEC_C,
    S_DEC_D,
    S_DONE
  } state_t;

endpackage

### src/kcie_div.sv
// ----------------------------------------------------------------------------
// kcie_div
// Restoring divider, one quotient bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
module kcie_div
  import kcie_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [VW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [VW-1:0]     dvd_r;
  logic [VW-1:0]     dsr_r;
  logic [VW-1:0]     rem_r;
  logic [VW:0]       trial;
  logic [VW:0]       diff;
  logic              ge;

  assign trial = {rem_r, dvd_r[VW-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CW'(VW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[VW-2:0], 1'b0};
      rem_r <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### src/kcie_front.sv
// ----------------------------------------------------------------------------
// kcie_front
// Takes requests, classifies them and range-checks, queues them for the back.
// ----------------------------------------------------------------------------
module kcie_front
  import kcie_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_mode,
  input  logic [IW-1:0] in_message,
  input  logic [IW-1:0] in_table_index,
  input  logic [VW-1:0] in_table_word,
  input  logic [VW-1:0] in_ciphertext,
  input  logic [VW-1:0] in_key,
  input  logic [VW-1:0] in_random_word,
  output logic          q_valid,
  output cmd_t          q_cmd,
  input  logic          q_pop
);

  cmd_t       q_r [Q_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cmd;
  logic       key_bad;

  assign key_bad = in_key >= cfg.key_count;

  always_comb begin
    cmd.message     = in_message;
    cmd.table_index = in_table_index;
    cmd.table_word  = in_table_word;
    cmd.ciphertext  = in_ciphertext;
    cmd.key         = in_key;
    cmd.random_word = in_random_word;
    case (in_mode)
      MODE_LOAD: cmd.op = OP_LOAD;
      MODE_ENC:  cmd.op = (({1'b0, in_message} >= cfg.msg_count) || key_bad) ? OP_ERR : OP_ENC;
      MODE_DEC:  cmd.op = ((in_ciphertext >= cfg.modulus) || key_bad) ? OP_ERR : OP_DEC;
      default:   cmd.op = OP_NOP;
    endcase
  end

  assign in_stall = cnt_r == 2'(Q_DEPTH);
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != '0;
  assign q_cmd    = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd;
  end

endmodule

### src/kcie_back.sv
// ----------------------------------------------------------------------------
// kcie_back
// Sequencer holding the weight table; runs loads, encodes and decodes.
// ----------------------------------------------------------------------------
`include "keyed_cell_interval_encoder_unit_defines.svh"

module kcie_back
  import kcie_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [VW-1:0] out_result,
  output logic          out_error
);

  state_t        state_r, state_nxt;
  cmd_t          cmd_r;
  logic [VW-1:0] tab_r [MAX_MSG];
  logic [VW-1:0] rd_r;
  logic [IW-1:0] rd_addr;
  logic [PW-1:0] prod_r;
  logic [VW-1:0] start_r;
  logic [VW-1:0] offset_r;
  logic [PW-1:0] acc_r;
  logic [VW-1:0] res_r;
  logic          err_r;
  logic          out_valid_r;
  logic [VW-1:0] out_result_r;
  logic          out_error_r;
  logic [VW-1:0] width;
  logic          div_start;
  logic          div_done;
  logic [VW-1:0] div_rem;
  logic          out_free;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [PW-1:0] mu64;

  assign mu64     = {{(PW-VW){1'b0}}, cfg.modulus};
  assign width    = rd_r - start_r;
  assign out_free = !out_valid_r || !out_stall;
  assign rd_addr  = (state_r == S_ENC_A) ? cmd_r.message - 1'b1 : cmd_r.message;

  kcie_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cmd_r.random_word),
    .divisor  (width),
    .done     (div_done),
    .rem      (div_rem)
  );

  // first entry above the remainder, among the messages in use
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = MAX_MSG - 1; i >= 0; i--) begin
      if ((MCW'(i) < cfg.msg_count) && (acc_r[PW-1:VW] == '0) && (acc_r[VW-1:0] < tab_r[i])) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_ENC:  state_nxt = S_ENC_A;
            OP_DEC:  state_nxt = S_DEC_A;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ENC_A: state_nxt = S_ENC_B;
      S_ENC_B: state_nxt = S_ENC_C;
      S_ENC_C: begin
        if (width == '0) begin
          state_nxt = S_ENC_SUM;
        end else begin
          div_start = 1'b1;
          state_nxt = S_ENC_DIV;
        end
      end
      S_ENC_DIV: if (div_done) state_nxt = S_ENC_SUM;
      S_ENC_SUM: state_nxt = S_ENC_WRAP;
      S_ENC_WRAP: state_nxt = S_DONE;
      S_DEC_A: state_nxt = S_DEC_B;
      S_DEC_B: state_nxt = S_DEC_C;
      S_DEC_C: state_nxt = S_DEC_D;
      S_DEC_D: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    rd_r <= tab_r[rd_addr];
    case (state_r)
      S_IDLE: begin
        cmd_r <= q_cmd;
        res_r <= '0;
        err_r <= q_cmd.op == OP_ERR;
        if (q_valid && q_cmd.op == OP_LOAD) tab_r[q_cmd.table_index] <= q_cmd.table_word;
      end
      S_ENC_A: prod_r <= PW'(cmd_r.key) * PW'(cfg.cell_width);
      S_ENC_B: start_r <= (cmd_r.message == '0) ? '0 : rd_r;
      S_ENC_C: offset_r <= '0;
      S_ENC_DIV: if (div_done) offset_r <= div_rem;
      S_ENC_SUM: acc_r <= PW'(start_r) + PW'(offset_r) + prod_r;
      S_ENC_WRAP: res_r <= (acc_r >= mu64) ? VW'(acc_r - mu64) : acc_r[VW-1:0];
      S_DEC_A: prod_r <= PW'(cmd_r.key) * PW'(cfg.cell_width);
      S_DEC_B: acc_r <= (prod_r > PW'(cmd_r.ciphertext)) ? PW'(cmd_r.ciphertext) + mu64
                                                          : PW'(cmd_r.ciphertext);
      S_DEC_C: acc_r <= acc_r - prod_r;
      S_DEC_D: begin
        res_r <= hit ? VW'(hit_idx) : '0;
        err_r <= !hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_result_r <= res_r;
      out_error_r  <= err_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  `KCIE_ASSERT_NOW(a_pop_idle, q_pop, state_r == S_IDLE, "queue popped outside idle")
  `KCIE_ASSERT_NOW(a_div_wait, div_done, state_r == S_ENC_DIV, "divider done while not waiting")
  `KCIE_ASSERT_NEXT(a_done_out, state_r == S_DONE && out_free, out_valid_r, "result not posted")
  `KCIE_ASSERT_NOW(a_err_zero, state_r == S_DONE && err_r, res_r == '0, "error with nonzero result")

endmodule

### src/keyed_cell_interval_encoder_unit.sv
// The back sequencer runs one request at a time; an encode waits on the remainder divider
// unless its interval is empty, while load, rejected and unused-mode requests go straight to
// the result handover. A 2-entry queue and the output register decouple the two sides.
// Reset (rst_n, synchronous): config to msg_count 1, key_count 0, modulus 1,
// cell_width 1; queue and output emptied; the weight table is not cleared.
module keyed_cell_interval_encoder_unit
  import kcie_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [CIW-1:0] cfg_index,
  input  logic [VW-1:0]  cfg_data,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_mode,
  input  logic [IW-1:0]  in_message,
  input  logic [IW-1:0]  in_table_index,
  input  logic [VW-1:0]  in_table_word,
  input  logic [VW-1:0]  in_ciphertext,
  input  logic [VW-1:0]  in_key,
  input  logic [VW-1:0]  in_random_word,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [VW-1:0]  out_result,
  output logic           out_error
);

  cfg_t cfg_r;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.msg_count  <= MCW'(1);
      cfg_r.key_count  <= '0;
      cfg_r.modulus    <= VW'(1);
      cfg_r.cell_width <= VW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MSG_COUNT:  cfg_r.msg_count  <= cfg_data[MCW-1:0];
        CFG_KEY_COUNT:  cfg_r.key_count  <= cfg_data;
        CFG_MODULUS:    cfg_r.modulus    <= cfg_data;
        CFG_CELL_WIDTH: cfg_r.cell_width <= cfg_data;
        default: ;
      endcase
    end
  end

  kcie_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_message     (in_message),
    .in_table_index (in_table_index),
    .in_table_word  (in_table_word),
    .in_ciphertext  (in_ciphertext),
    .in_key         (in_key),
    .in_random_word (in_random_word),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop)
  );

  kcie_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .out_error  (out_error)
  );

endmodule

### verif/keyed_cell_interval_encoder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed cell interval encoder unit test
// Drives load, encode, decode and unused-mode requests under random sender gaps
// and receiver stalls, predicts each result from a local table and register copy,
// and checks every result in order against the predicted queue.
// ----------------------------------------------------------------------------
module keyed_cell_interval_encoder_unit_test
  import kcie_pkg::*;
();

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [VW-1:0] result;
    logic          error;
  } outcome_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [CIW-1:0] cfg_index;
  logic [VW-1:0]  cfg_data;
  logic           in_valid;
  logic           in_stall;
  logic [1:0]     in_mode;
  logic [IW-1:0]  in_message;
  logic [IW-1:0]  in_table_index;
  logic [VW-1:0]  in_table_word;
  logic [VW-1:0]  in_ciphertext;
  logic [VW-1:0]  in_key;
  logic [VW-1:0]  in_random_word;
  logic           out_valid;
  logic           out_stall;
  logic [VW-1:0]  out_result;
  logic           out_error;

  // local copy of block state
  logic [VW-1:0]  weight_table [MAX_MSG];
  logic [MCW-1:0] msg_count_q;
  logic [VW-1:0]  key_count_q;
  logic [VW-1:0]  modulus_q;
  logic [VW-1:0]  cell_width_q;

  outcome_t pending_outcomes[$];
  int       error_count;
  int       results_seen;
  int       requests_sent;
  int       idle_cycles;
  int       stall_mode;

  keyed_cell_interval_encoder_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int active_count();
    return (msg_count_q < MAX_MSG) ? int'(msg_count_q) : MAX_MSG;
  endfunction

  function automatic outcome_t predict_outcome(logic [1:0] mode, logic [IW-1:0] msg,
      logic [IW-1:0] tidx, logic [VW-1:0] tword, logic [VW-1:0] ctext,
      logic [VW-1:0] key, logic [VW-1:0] rnd);
    outcome_t o;
    logic [PW-1:0] start, width, sum, shift, c, rem;
    o.result = '0;
    o.error = 1'b0;
    case (mode)
      MODE_LOAD: begin
        weight_table[tidx] = tword;
      end
      MODE_ENC: begin
        if (msg >= active_count() || key >= key_count_q) begin
          o.error = 1'b1;
        end else begin
          start = (msg == 0) ? '0 : PW'(weight_table[msg-1]);
          width = (msg == 0) ? PW'(weight_table[0])
                             : PW'(VW'(weight_table[msg] - weight_table[msg-1]));
          sum = start + ((width == 0) ? '0 : PW'(rnd) % width)
              + PW'(key) * PW'(cell_width_q);
          if (sum >= PW'(modulus_q)) sum = sum - PW'(modulus_q);
          o.result = sum[VW-1:0];
        end
      end
      MODE_DEC: begin
        if (ctext >= modulus_q || key >= key_count_q) begin
          o.error = 1'b1;
        end else begin
          shift = PW'(key) * PW'(cell_width_q);
          c = PW'(ctext);
          if (shift > c) c = c + PW'(modulus_q);
          rem = c - shift;
          o.error = 1'b1;
          for (int i = active_count() - 1; i >= 0; i--)
            if (rem < PW'(weight_table[i])) begin
              o.result = VW'(i);
              o.error = 1'b0;
            end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_request(logic [1:0] mode, logic [VW-1:0] msg, logic [VW-1:0] tidx,
      logic [VW-1:0] tword, logic [VW-1:0] ctext, logic [VW-1:0] key, logic [VW-1:0] rnd);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_message <= IW'(msg);
    in_table_index <= IW'(tidx);
    in_table_word <= tword;
    in_ciphertext <= ctext;
    in_key <= key;
    in_random_word <= rnd;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(predict_outcome(mode, IW'(msg), IW'(tidx), tword, ctext,
                                               key, rnd));
    requests_sent++;
  endtask

  // burst of back-to-back requests, then a random gap or none
  int burst_left;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 30);
    if ($urandom_range(0, 3) != 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIW-1:0] idx, logic [VW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MSG_COUNT: msg_count_q = val[MCW-1:0];
      CFG_KEY_COUNT: key_count_q = val;
      CFG_MODULUS: modulus_q = val;
      default: cell_width_q = val;
    endcase
  endtask

  task automatic configure(int n, logic [VW-1:0] keys, logic [VW-1:0] mu, logic [VW-1:0] x);
    write_reg(CFG_MSG_COUNT, n);
    write_reg(CFG_KEY_COUNT, keys);
    write_reg(CFG_MODULUS, mu);
    write_reg(CFG_CELL_WIDTH, x);
  endtask

  // cumulative table of n entries ending at mu, optionally with a zero-width cell
  task automatic load_table(int n, logic [VW-1:0] mu, bit empty_cell);
    logic [VW-1:0] w [MAX_MSG];
    logic [VW-1:0] step;
    step = mu / n;
    for (int i = 0; i < n; i++) begin
      w[i] = (i == n - 1) ? mu : step * (i + 1) - VW'($urandom_range(0, step > 2 ? 1 : 0));
      if (empty_cell && i == n / 2 && i > 0 && i < n - 1) w[i] = w[i-1];
    end
    for (int i = 0; i < n; i++) begin
      send_request(MODE_LOAD, $urandom, i, w[i], $urandom, $urandom, $urandom);
      pace();
    end
  endtask

  task automatic random_request();
    int n;
    logic [VW-1:0] key;
    n = active_count();
    key = (key_count_q == 0) ? $urandom : VW'($urandom_range(0, key_count_q - 1));
    if ($urandom_range(0, 15) == 0) key = $urandom;
    case ($urandom_range(0, 19))
      0: send_request(MODE_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      1, 2: send_request(MODE_ENC, $urandom, 0, $urandom, $urandom, key, $urandom);
      3, 4: send_request(MODE_DEC, 0, 0, $urandom, $urandom, key, $urandom);
      5, 6, 7, 8, 9, 10, 11:
        send_request(MODE_ENC, $urandom_range(0, n - 1), $urandom, $urandom, $urandom,
                     key, $urandom);
      default:
        send_request(MODE_DEC, $urandom, $urandom, $urandom,
                     (modulus_q == 0) ? $urandom : VW'($urandom) % modulus_q, key, $urandom);
    endcase
  endtask

  task automatic test_directed();
    configure(4, 3, 100, 25);
    load_table(4, 100, 1'b0);
    send_request(MODE_ENC, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_request(MODE_ENC, 3, 0, 0, 0, 2, 0);
    send_request(MODE_ENC, 3, 0, 0, 0, 2, 32'hFFFF_FFFF);
    send_request(MODE_ENC, 4, 0, 0, 0, 0, 5);        // message out of range
    send_request(MODE_ENC, 15, 0, 0, 0, 0, 5);
    send_request(MODE_ENC, 1, 0, 0, 0, 3, 5);        // key out of range
    send_request(MODE_ENC, 1, 0, 0, 0, 32'hFFFF_FFFF, 5);
    send_request(MODE_DEC, 0, 0, 0, 0, 0, 0);
    send_request(MODE_DEC, 0, 0, 0, 99, 2, 0);
    send_request(MODE_DEC, 0, 0, 0, 10, 2, 0);       // shift exceeds ciphertext
    send_request(MODE_DEC, 0, 0, 0, 100, 0, 0);      // ciphertext out of range
    send_request(MODE_DEC, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    send_request(MODE_DEC, 0, 0, 0, 5, 3, 0);
    send_request(MODE_UNUSED, 15, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    drain();
    // descending table: wrapped width and a decode with no match
    write_reg(CFG_MSG_COUNT, 2);
    send_request(MODE_LOAD, 0, 0, 60, 0, 0, 0);
    send_request(MODE_LOAD, 0, 1, 40, 0, 0, 0);
    send_request(MODE_ENC, 1, 0, 0, 0, 1, 32'hFFFF_FFFF);
    send_request(MODE_DEC, 0, 0, 0, 85, 0, 0);
    drain();
  endtask

  task automatic test_extremes();
    // largest modulus, one message, zero keys then all keys
    configure(1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_LOAD, 0, 0, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(MODE_ENC, 0, 0, 0, 0, 0, 7);
    drain();
    configure(16, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_table(16, 32'hFFFF_FFFF, 1'b1);
    send_request(MODE_ENC, 15, 0, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(MODE_DEC, 0, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFE, 0);
    send_request(MODE_DEC, 0, 0, 0, 1, 32'hFFFF_FFFE, 0);
    drain();
    configure(16, 1, 1, 1);
    drain();
  endtask

  task automatic test_random(int count);
    int n;
    logic [VW-1:0] mu, x;
    while (count > 0) begin
      n = ($urandom_range(0, 4) == 0) ? 16 : $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0: mu = $urandom_range(n, 64);
        1: mu = 32'hFFFF_FFFF - $urandom_range(0, 100);
        default: mu = $urandom_range(n, 32'h7FFF_FFFF);
      endcase
      x = ($urandom_range(0, 3) == 0) ? mu : $urandom_range(1, (mu / n) + 1);
      stall_mode = $urandom_range(0, 3);
      configure(n, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 40), mu, x);
      load_table(n, mu, $urandom_range(0, 1));
      repeat (150) begin
        random_request();
        pace();
      end
      count -= 150 + n;
      drain();
    end
  endtask

  // receiver stalls on a pattern chosen per phase
  always @(posedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    outcome_t exp_o;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result %0h error %0b", out_result, out_error);
        error_count++;
      end else begin
        exp_o = pending_outcomes.pop_front();
        if (out_result !== exp_o.result) begin
          $error("result: expected %0h actual %0h", exp_o.result, out_result);
          error_count++;
        end
        if (out_error !== exp_o.error) begin
          $error("error: expected %0b actual %0b", exp_o.error, out_error);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_mode = '0;
    in_message = '0;
    in_table_index = '0;
    in_table_word = '0;
    in_ciphertext = '0;
    in_key = '0;
    in_random_word = '0;
    out_stall = 1'b0;
    stall_mode = 1;
    error_count = 0;
    results_seen = 0;
    requests_sent = 0;
    idle_cycles = 0;
    burst_left = 0;
    msg_count_q = 1;
    key_count_q = 0;
    modulus_q = 1;
    cell_width_q = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extremes();
    test_random(1950);
    $display("Covered %0d requests and %0d results over load, encode, decode and unused modes",
             requests_sent, results_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
